/* src/acm_pkg.sv */
package acm_pkg;

	localparam int SAMPLE_W  = 24;
	localparam int COEF_W    = 18;
	localparam int COEF_FRAC = COEF_W - 4;
	localparam int PROD_W    = SAMPLE_W + COEF_W;
	localparam int ACC_W     = 45;
	localparam int NUM_CH    = 8;
	localparam int CH_W      = 3;
	localparam int ADDR_W    = 2 * CH_W;
	localparam int CNT_W     = 4;
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 32;

	localparam logic OPC_SAMPLE = 1'b0;
	localparam logic OPC_COEF   = 1'b1;

	localparam logic CFG_IN_COUNT  = 1'b0;
	localparam logic CFG_OUT_COUNT = 1'b1;

	localparam logic [CNT_W-1:0] COUNT_RESET = 4'd2;

	typedef struct packed {
		logic            coef_we;
		logic            sample_ld;
		logic            mac_issue;
		logic [CH_W-1:0] mac_row;
		logic [CH_W-1:0] col;
		logic            emit_ld;
		logic [CH_W-1:0] emit_ch;
		logic            emit_last;
		logic            acc_clr;
	} acm_cmd_t;

	typedef struct packed {
		logic out_free;
	} acm_sts_t;

	// A count of zero means one channel; anything above the store size is capped.
	function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] c);
		logic [CNT_W-1:0] r;
		if (c == '0) begin
			r = CNT_W'(1);
		end else if (c > CNT_W'(NUM_CH)) begin
			r = CNT_W'(NUM_CH);
		end else begin
			r = c;
		end
		return r;
	endfunction

endpackage

/* src/audio_channel_matrix_mixer.sv */
// Sample item: accepted while idle, then a multiply-accumulate pass over the output channels,
// one product a cycle through the coefficient memory read and the multiplier stage.
// At frame end each output channel's result moves to the output register in turn, waiting while it is not free.
// No new item is accepted until the pass, and at frame end the output of every channel, is done.
// Reset clears the counts to two, the accumulators and all coefficient valid bits at once.
module audio_channel_matrix_mixer
	import acm_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic                   cfg_addr,
	input  logic [CNT_W-1:0]       cfg_wdata,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// sample_value[23:0], coef_out_index[26:24], coef_in_index[29:27], coef_value[47:30]
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// opcode
	input  logic                   s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// mixed_sample[23:0], out_channel[26:24], zero fill[31:27]
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   m_tlast
);

	acm_cmd_t                   cmd;
	acm_sts_t                   sts;
	logic signed [SAMPLE_W-1:0] mixed_sample;
	logic [CH_W-1:0]            out_channel;

	acm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tuser   (s_tuser),
		.s_tready  (s_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	acm_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.sample_value   (s_tdata[SAMPLE_W-1:0]),
		.coef_out_index (s_tdata[SAMPLE_W+CH_W-1:SAMPLE_W]),
		.coef_in_index  (s_tdata[SAMPLE_W+2*CH_W-1:SAMPLE_W+CH_W]),
		.coef_value     (s_tdata[SAMPLE_W+2*CH_W+COEF_W-1:SAMPLE_W+2*CH_W]),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.mixed_sample   (mixed_sample),
		.out_channel    (out_channel),
		.last_in_frame  (m_tlast)
	);

	assign m_tdata = {{(OUT_TDATA_W - SAMPLE_W - CH_W){1'b0}}, out_channel, mixed_sample};

endmodule

/* src/acm_ctrl.sv */
module acm_ctrl
	import acm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic             cfg_addr,
	input  logic [CNT_W-1:0] cfg_wdata,
	input  logic             s_tvalid,
	input  logic             s_tuser,
	output logic             s_tready,
	input  acm_sts_t         sts,
	output acm_cmd_t         cmd
);

	typedef enum logic [1:0] {ST_IDLE, ST_MAC, ST_EMIT} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  in_cnt_q;
	logic [CNT_W-1:0]  out_cnt_q;
	logic [CH_W-1:0]   pos_q;
	logic [CNT_W-1:0]  step_q;
	logic [CH_W-1:0]   och_q;

	logic [CNT_W-1:0]  n_in;
	logic [CNT_W-1:0]  n_out;
	logic              accept;
	logic              emit_last;

	assign n_in      = clamp_count(in_cnt_q);
	assign n_out     = clamp_count(out_cnt_q);
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign emit_last = ({1'b0, och_q} == n_out - CNT_W'(1));

	always_comb begin
		cmd           = '0;
		cmd.coef_we   = accept && (s_tuser == OPC_COEF);
		cmd.sample_ld = accept && (s_tuser == OPC_SAMPLE);
		cmd.col       = pos_q;
		cmd.mac_issue = (state_q == ST_MAC) && (step_q < n_out);
		cmd.mac_row   = step_q[CH_W-1:0];
		cmd.emit_ld   = (state_q == ST_EMIT) && sts.out_free;
		cmd.emit_ch   = och_q;
		cmd.emit_last = emit_last;
		cmd.acc_clr   = cmd.emit_ld && emit_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			in_cnt_q  <= COUNT_RESET;
			out_cnt_q <= COUNT_RESET;
			pos_q     <= '0;
			step_q    <= '0;
			och_q     <= '0;
		end else begin
			if (cfg_wr_en) begin
				if (cfg_addr == CFG_IN_COUNT) begin
					in_cnt_q <= cfg_wdata;
				end else begin
					out_cnt_q <= cfg_wdata;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && (s_tuser == OPC_SAMPLE)) begin
						state_q <= ST_MAC;
						step_q  <= '0;
					end
				end
				ST_MAC: begin
					// Waits until the last product has landed in its accumulator.
					if (step_q == n_out + CNT_W'(1)) begin
						if ({1'b0, pos_q} + CNT_W'(1) < n_in) begin
							pos_q   <= pos_q + CH_W'(1);
							state_q <= ST_IDLE;
						end else begin
							pos_q   <= '0;
							och_q   <= '0;
							state_q <= ST_EMIT;
						end
					end else begin
						step_q <= step_q + CNT_W'(1);
					end
				end
				ST_EMIT: begin
					if (sts.out_free) begin
						if (emit_last) begin
							state_q <= ST_IDLE;
						end else begin
							och_q <= och_q + CH_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_sample_starts_mac: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == OPC_SAMPLE) |=> (state_q == ST_MAC))
		else $error("sample item did not start the multiply pass");

	a_emit_pos_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (pos_q == '0))
		else $error("channel position not cleared during frame output");

	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc_clr |-> (cmd.emit_ld && {1'b0, cmd.emit_ch} == n_out - CNT_W'(1)))
		else $error("accumulators cleared before the last output channel");

	a_no_issue_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mac_issue |-> !s_tready)
		else $error("multiply issued while input is open");

endmodule

/* src/acm_datapath.sv */
module acm_datapath
	import acm_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  acm_cmd_t                   cmd,
	output acm_sts_t                   sts,
	input  logic signed [SAMPLE_W-1:0] sample_value,
	input  logic [CH_W-1:0]            coef_out_index,
	input  logic [CH_W-1:0]            coef_in_index,
	input  logic signed [COEF_W-1:0]   coef_value,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic signed [SAMPLE_W-1:0] mixed_sample,
	output logic [CH_W-1:0]            out_channel,
	output logic                       last_in_frame
);

	localparam int DEPTH = NUM_CH * NUM_CH;
	localparam int SH_W  = ACC_W + 1 - COEF_FRAC;

	logic signed [COEF_W-1:0]   coef_mem [DEPTH];
	logic [DEPTH-1:0]           coef_vld_q;
	logic [ADDR_W-1:0]          waddr;
	logic [ADDR_W-1:0]          raddr;

	logic signed [SAMPLE_W-1:0] sample_q;
	logic signed [COEF_W-1:0]   coef_rd_s1;
	logic                       vld_s1;
	logic                       mac_s1;
	logic [CH_W-1:0]            row_s1;
	logic signed [COEF_W-1:0]   coef_g;
	logic signed [PROD_W-1:0]   prod;
	logic signed [PROD_W-1:0]   prod_s2;
	logic                       mac_s2;
	logic [CH_W-1:0]            row_s2;
	logic signed [ACC_W-1:0]    acc_q [NUM_CH];

	logic signed [ACC_W-1:0]    acc_sel;
	logic signed [ACC_W:0]      rnd;
	logic signed [SH_W-1:0]     sh;
	logic signed [SAMPLE_W-1:0] sat;
	logic                       m_tvalid_q;

	assign waddr = {coef_out_index, coef_in_index};
	assign raddr = {cmd.mac_row, cmd.col};

	always_ff @(posedge clk) begin
		if (cmd.coef_we) begin
			coef_mem[waddr] <= coef_value;
		end
		coef_rd_s1 <= coef_mem[raddr];
		if (cmd.sample_ld) begin
			sample_q <= sample_value;
		end
		row_s1  <= cmd.mac_row;
		row_s2  <= row_s1;
		prod_s2 <= prod;
	end

	// Entries never written since reset read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_vld_q <= '0;
			vld_s1     <= 1'b0;
			mac_s1     <= 1'b0;
			mac_s2     <= 1'b0;
		end else begin
			if (cmd.coef_we) begin
				coef_vld_q[waddr] <= 1'b1;
			end
			vld_s1 <= coef_vld_q[raddr];
			mac_s1 <= cmd.mac_issue;
			mac_s2 <= mac_s1;
		end
	end

	assign coef_g = vld_s1 ? coef_rd_s1 : '0;
	assign prod   = sample_q * coef_g;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CH; i++) begin
				acc_q[i] <= '0;
			end
		end else if (cmd.acc_clr) begin
			for (int i = 0; i < NUM_CH; i++) begin
				acc_q[i] <= '0;
			end
		end else if (mac_s2) begin
			acc_q[row_s2] <= acc_q[row_s2] + {{(ACC_W - PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
		end
	end

	// Round half up to Q1.23, then saturate.
	always_comb begin
		acc_sel = acc_q[cmd.emit_ch];
		rnd     = {acc_sel[ACC_W-1], acc_sel} + (ACC_W+1)'(1 << (COEF_FRAC - 1));
		sh      = rnd[ACC_W:COEF_FRAC];
		if (sh[SH_W-1:SAMPLE_W-1] == '0 || sh[SH_W-1:SAMPLE_W-1] == '1) begin
			sat = sh[SAMPLE_W-1:0];
		end else if (sh[SH_W-1]) begin
			sat = {1'b1, {(SAMPLE_W - 1){1'b0}}};
		end else begin
			sat = {1'b0, {(SAMPLE_W - 1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_ld) begin
			mixed_sample  <= sat;
			out_channel   <= cmd.emit_ch;
			last_in_frame <= cmd.emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.emit_ld) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid     = m_tvalid_q;
	assign sts.out_free = !m_tvalid_q || m_tready;

	a_clear_not_mac: assert property (@(posedge clk) disable iff (!arst_n)
		mac_s2 |-> !cmd.acc_clr)
		else $error("accumulator clear collides with a pending product");

	a_no_write_in_mac: assert property (@(posedge clk) disable iff (!arst_n)
		(mac_s1 || mac_s2 || cmd.mac_issue) |-> !cmd.coef_we)
		else $error("coefficient write during a multiply pass");

	a_pipe_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mac_issue |=> mac_s1 ##1 mac_s2)
		else $error("multiply pipeline lost a product");

endmodule
